// ----- sv/dfcr_pkg.sv -----
// Shared constants, codes and the reply table of the fault code reader session.
`timescale 1ns / 1ps

package dfcr_pkg;

  // Payload widths.
  localparam int RxWidth       = 8;
  localparam int ReplyWidth    = 8;
  localparam int CodeWidth     = 12;
  localparam int WordWidth     = 32;
  localparam int NumSyncWords  = 4;
  localparam int SyncIdxWidth  = $clog2(NumSyncWords);
  localparam int CountWidth    = 4;

  // Output beat packing: reply_first, reply_second, fault_code, zero fill.
  localparam int TdataRaw      = 2 * ReplyWidth + CodeWidth;
  localparam int TdataWidth    = ((TdataRaw + 7) / 8) * 8;
  localparam int TdataPad      = TdataWidth - TdataRaw;

  // Configuration register indexes.
  typedef enum logic [SyncIdxWidth-1:0] {
    REG_SYNC_WORD_0 = 2'd0,
    REG_SYNC_WORD_1 = 2'd1,
    REG_SYNC_WORD_2 = 2'd2,
    REG_SYNC_WORD_3 = 2'd3
  } reg_index_t;

  // Result kinds carried on tuser.
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_CODE  = 1'b1;

  // Phase lengths: the counters wrap when the incremented count passes these.
  localparam logic [CountWidth-1:0] FullSyncRounds  = 4'd7;
  localparam logic [CountWidth-1:0] ShortSyncRounds = 4'd3;
  localparam logic [CountWidth-1:0] DiscardBytes    = 4'd5;
  localparam logic [CountWidth-1:0] FinalCodes      = 4'd7;

  // Fixed two-byte reply for each sync signature, first byte in the high half.
  function automatic logic [2*ReplyWidth-1:0] reply_bytes(
    input logic [SyncIdxWidth-1:0] idx
  );
    logic [2*ReplyWidth-1:0] r;
    case (idx)
      2'd0:    r = {8'h01, 8'hB0};
      2'd1:    r = {8'hFF, 8'h5F};
      2'd2:    r = {8'h25, 8'h94};
      2'd3:    r = {8'h00, 8'hA0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/diag_fault_code_reader_fsm_core.sv -----
// Fault code reader session controller: sync matching, replies and code reads.
// A result beat is registered and presented in the cycle after the byte beat that causes it.
// Throughput: one byte beat per cycle; only a stalled output register holds input off.
// Each byte is decoded by its phase: one compare against the selected sync word in the sync phases, counter updates.
// Reset (synchronous, active high) clears the window, counters, phase and sync words.
`timescale 1ns / 1ps

module diag_fault_code_reader_fsm_core (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream; tdata: rx_byte[7:0].
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dfcr_pkg::RxWidth-1:0]        s_axis_tdata,
  // Output stream; tdata: reply_first[7:0], reply_second[15:8], fault_code[27:16],
  // zero fill[31:28]; tuser: kind[0]; tlast: session_done.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dfcr_pkg::TdataWidth-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dfcr_pkg::SyncIdxWidth-1:0]   cfg_index,
  input  logic [dfcr_pkg::WordWidth-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    PH_FULL_SYNC  = 3'd0,
    PH_SHORT_SYNC = 3'd1,
    PH_CODE_READ  = 3'd2,
    PH_DISCARD    = 3'd3,
    PH_FINAL_READ = 3'd4
  } phase_t;

  // Session state.
  phase_t                                 phase, phase_next;
  logic [dfcr_pkg::WordWidth-1:0]         byte_window, byte_window_next;
  logic [dfcr_pkg::SyncIdxWidth-1:0]      sync_index, sync_index_next;
  logic [dfcr_pkg::CountWidth-1:0]        phase_count, phase_count_next;
  logic [dfcr_pkg::CountWidth-1:0]        code_count, code_count_next;
  logic                                   code_byte_index, code_byte_index_next;
  logic [dfcr_pkg::WordWidth-1:0]         sync_word [dfcr_pkg::NumSyncWords];

  // Result computed for the current byte.
  logic                                   res_valid;
  logic                                   res_kind;
  logic [2*dfcr_pkg::ReplyWidth-1:0]      res_reply;
  logic [dfcr_pkg::CodeWidth-1:0]         res_code;
  logic                                   res_done;

  logic                                   in_beat;
  logic [dfcr_pkg::WordWidth-1:0]         shifted;
  logic                                   sync_hit;
  logic [dfcr_pkg::CountWidth-1:0]        phase_count_inc;
  logic [dfcr_pkg::CountWidth-1:0]        code_count_inc;

  // The output register frees up when empty or when its beat is taken.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign shifted         = {byte_window[dfcr_pkg::WordWidth-dfcr_pkg::RxWidth-1:0], s_axis_tdata};
  assign sync_hit        = (shifted == sync_word[sync_index]);
  assign phase_count_inc = phase_count + 4'd1;
  assign code_count_inc  = code_count + 4'd1;

  // Per-byte phase decode and counter updates.
  always_comb begin
    phase_next           = phase;
    byte_window_next     = byte_window;
    sync_index_next      = sync_index;
    phase_count_next     = phase_count;
    code_count_next      = code_count;
    code_byte_index_next = code_byte_index;
    res_valid            = 1'b0;
    res_kind             = dfcr_pkg::KIND_REPLY;
    res_reply            = '0;
    res_code             = '0;
    res_done             = 1'b0;
    case (phase)
      PH_FULL_SYNC: begin
        byte_window_next = shifted;
        if (sync_hit) begin
          res_valid       = 1'b1;
          res_reply       = dfcr_pkg::reply_bytes(sync_index);
          sync_index_next = sync_index + 2'd1;
          if (sync_index_next == '0) begin
            phase_count_next = phase_count_inc;
            if (phase_count_inc > dfcr_pkg::FullSyncRounds) begin
              phase_count_next = '0;
              phase_next       = PH_SHORT_SYNC;
            end
          end
        end
      end
      PH_SHORT_SYNC: begin
        byte_window_next = shifted;
        if (sync_hit) begin
          res_valid       = 1'b1;
          res_reply       = dfcr_pkg::reply_bytes(sync_index);
          sync_index_next = sync_index + 2'd1;
          phase_next      = PH_CODE_READ;
        end
      end
      PH_CODE_READ: begin
        byte_window_next     = shifted;
        code_byte_index_next = !code_byte_index;
        if (code_byte_index) begin
          res_valid        = 1'b1;
          res_kind         = dfcr_pkg::KIND_CODE;
          res_code         = {shifted[3:0], shifted[15:8]};
          phase_next       = PH_SHORT_SYNC;
          phase_count_next = phase_count_inc;
          if (phase_count_inc > dfcr_pkg::ShortSyncRounds) begin
            phase_count_next = '0;
            phase_next       = PH_DISCARD;
          end
        end
      end
      PH_DISCARD: begin
        phase_count_next = phase_count_inc;
        if (phase_count_inc > dfcr_pkg::DiscardBytes) begin
          phase_count_next = '0;
          phase_next       = PH_FINAL_READ;
        end
      end
      PH_FINAL_READ: begin
        byte_window_next     = shifted;
        code_byte_index_next = !code_byte_index;
        if (code_byte_index) begin
          res_valid       = 1'b1;
          res_kind        = dfcr_pkg::KIND_CODE;
          res_code        = {shifted[3:0], shifted[15:8]};
          phase_next      = PH_DISCARD;
          code_count_next = code_count_inc;
          if (code_count_inc > dfcr_pkg::FinalCodes) begin
            code_count_next = '0;
            phase_next      = PH_FULL_SYNC;
            res_done        = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_FULL_SYNC;
      end
    endcase
  end

  // State, configuration and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FULL_SYNC;
      byte_window     <= '0;
      sync_index      <= '0;
      phase_count     <= '0;
      code_count      <= '0;
      code_byte_index <= 1'b0;
      m_axis_tvalid   <= 1'b0;
      for (int i = 0; i < dfcr_pkg::NumSyncWords; i++) begin
        sync_word[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dfcr_pkg::REG_SYNC_WORD_0: sync_word[0] <= cfg_data;
          dfcr_pkg::REG_SYNC_WORD_1: sync_word[1] <= cfg_data;
          dfcr_pkg::REG_SYNC_WORD_2: sync_word[2] <= cfg_data;
          dfcr_pkg::REG_SYNC_WORD_3: sync_word[3] <= cfg_data;
          default: ;
        endcase
      end
      if (in_beat) begin
        phase           <= phase_next;
        byte_window     <= byte_window_next;
        sync_index      <= sync_index_next;
        phase_count     <= phase_count_next;
        code_count      <= code_count_next;
        code_byte_index <= code_byte_index_next;
        m_axis_tvalid   <= res_valid;
        // The payload is loaded only on an accepted byte that produces a result.
        if (res_valid) begin
          m_axis_tdata <= {{dfcr_pkg::TdataPad{1'b0}}, res_code,
                           res_reply[dfcr_pkg::ReplyWidth-1:0],
                           res_reply[2*dfcr_pkg::ReplyWidth-1:dfcr_pkg::ReplyWidth]};
          m_axis_tuser <= res_kind;
          m_axis_tlast <= res_done;
        end
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule
